[sv/wbs_pkg.sv]
`default_nettype none

package wbs_pkg;

	// Field and state widths.
	localparam int NUM_BANDS       = 4;
	localparam int BAND_W          = 2;
	localparam int SAMPLE_W        = 12;
	localparam int LEVEL_W         = 12;
	localparam int COUNT_W         = 16;
	localparam int SUM_W           = 28;
	localparam int SQ_W            = 40;
	localparam int GEN_W           = 16;
	localparam int WIN_W           = 16;
	localparam int NUM_WINDOW_REGS = 4;
	localparam int CFG_IDX_W       = 2;

	// Stream payload widths.
	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 4 * LEVEL_W + GEN_W;

	localparam logic [SAMPLE_W-1:0] LEVEL_MAX = '1;

	localparam logic [WIN_W-1:0] WINDOW_RESET [NUM_WINDOW_REGS] = '{
		WIN_W'(2000), WIN_W'(100), WIN_W'(10), WIN_W'(10)
	};

	// One band's accumulators as kept in the state memory.
	typedef struct packed {
		logic [COUNT_W-1:0]  count;
		logic [SUM_W-1:0]    sum;
		logic [SQ_W-1:0]     sqsum;
		logic [SAMPLE_W-1:0] min_v;
		logic [SAMPLE_W-1:0] max_v;
		logic [GEN_W-1:0]    pub;
	} band_entry_t;

	// Sequencer of the top level.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPD,
		ST_CALC,
		ST_OUT
	} top_state_t;

	// Sequencer of the statistics unit.
	typedef enum logic [2:0] {
		CS_IDLE,
		CS_MULA,
		CS_MULB,
		CS_MULC,
		CS_DIFF,
		CS_ROOTA,
		CS_ROOTB,
		CS_DONE
	} calc_state_t;

	// Accumulators of a band that has just been cleared, keeping its publish count.
	function automatic band_entry_t cleared_entry(input logic [GEN_W-1:0] pub);
		band_entry_t e;
		e.count = '0;
		e.sum   = '0;
		e.sqsum = '0;
		e.min_v = LEVEL_MAX;
		e.max_v = '0;
		e.pub   = pub;
		return e;
	endfunction

endpackage

`default_nettype wire

[sv/windowed_band_statistics.sv]
`default_nettype none

// Channel    Direction  Beat contents
// s_*        in         tuser: band; tdata: sample, zero filled to 16 bits
// m_*        out        tuser: out_band; tdata: mean, deviation, min, max, generation
// cfg_*      in         window length write, one register per band
//
// A sample that does not close its band's window reads the band's accumulators
// from the state memory on accept and writes them back in the update state.
// A sample that closes a window also passes through the statistics unit,
// whose 12-bit deviation search tries one bit at a time. The result then waits
// in the output register while the next sample is taken; a second result
// stalls the block until the first beat is taken. Reset clears every band.
module windowed_band_statistics (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// Input stream.
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [wbs_pkg::S_TDATA_W-1:0]    s_tdata,  // [11:0] sample
	input  wire logic [wbs_pkg::BAND_W-1:0]       s_tuser,  // [1:0] band
	// Result stream.
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// [11:0] mean_level, [23:12] deviation_level, [35:24] min_level,
	// [47:36] max_level, [63:48] generation
	output logic [wbs_pkg::M_TDATA_W-1:0]         m_tdata,
	output logic [wbs_pkg::BAND_W-1:0]            m_tuser,  // [1:0] out_band
	// Configuration writes.
	input  wire logic                             cfg_we,
	input  wire logic [wbs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [wbs_pkg::WIN_W-1:0]        cfg_data
);

	import wbs_pkg::*;

	top_state_t state_q, state_d;

	logic [WIN_W-1:0]    window_q [NUM_WINDOW_REGS];

	band_entry_t         mem [NUM_BANDS];
	band_entry_t         rd_q;
	logic [NUM_BANDS-1:0] valid_q;
	logic                entry_valid_q;

	logic [BAND_W-1:0]   in_band_q;
	logic [SAMPLE_W-1:0] in_sample_q;

	logic [BAND_W-1:0]   res_band_q;
	logic [SAMPLE_W-1:0] res_min_q;
	logic [SAMPLE_W-1:0] res_max_q;
	logic [GEN_W-1:0]    res_gen_q;

	logic                m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic [BAND_W-1:0]   m_tuser_q;

	logic                accept;
	logic                band_ok;
	logic                mem_we;
	logic                calc_start;
	logic                load_out;
	logic                calc_done;
	logic [LEVEL_W-1:0]  calc_mean;
	logic [LEVEL_W-1:0]  calc_dev;

	band_entry_t         cur;
	band_entry_t         upd;
	band_entry_t         wr_entry;
	logic                first;
	logic [2*SAMPLE_W-1:0] v_sq;
	logic                close;

	assign accept  = s_tvalid && s_tready;
	assign band_ok = ({1'b0, s_tuser} < (BAND_W+1)'(NUM_BANDS));

	// Window length registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_WINDOW_REGS; i++) begin
				window_q[i] <= WINDOW_RESET[i];
			end
		end else if (cfg_we) begin
			window_q[cfg_index] <= cfg_data;
		end
	end

	// Read-modify-write of the band entry fetched in the previous cycle.
	always_comb begin
		cur      = entry_valid_q ? rd_q : cleared_entry('0);
		first    = (cur.count == '0);
		v_sq     = in_sample_q * in_sample_q;
		upd.count = cur.count + COUNT_W'(1);
		upd.sum   = cur.sum + SUM_W'(in_sample_q);
		upd.sqsum = cur.sqsum + SQ_W'(v_sq);
		upd.min_v = (first || in_sample_q < cur.min_v) ? in_sample_q : cur.min_v;
		upd.max_v = (first || in_sample_q > cur.max_v) ? in_sample_q : cur.max_v;
		// A zero window length closes on every sample, as a length of one.
		close     = (upd.count >= window_q[in_band_q]);
		upd.pub   = close ? cur.pub + GEN_W'(1) : cur.pub;
		wr_entry  = close ? cleared_entry(upd.pub) : upd;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept && band_ok) state_d = ST_UPD;
			ST_UPD:  state_d = close ? ST_CALC : ST_IDLE;
			ST_CALC: if (calc_done) state_d = ST_OUT;
			ST_OUT:  if (!m_tvalid_q || m_tready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		s_tready   = (state_q == ST_IDLE);
		mem_we     = (state_q == ST_UPD);
		calc_start = (state_q == ST_UPD) && close;
		load_out   = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Per-band valid bits: an entry not yet written reads as cleared.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (mem_we) begin
			valid_q[in_band_q] <= 1'b1;
		end
	end

	// State memory: one entry per band, read on accept, written back in the next cycle.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[in_band_q] <= wr_entry;
		end
		if (accept) begin
			rd_q <= mem[s_tuser];
		end
	end

	// Captured input beat and the valid bit of its entry.
	always_ff @(posedge clk) begin
		if (accept) begin
			in_band_q     <= s_tuser;
			in_sample_q   <= s_tdata[SAMPLE_W-1:0];
			entry_valid_q <= valid_q[s_tuser];
		end
	end

	// Result fields that need no further computation.
	always_ff @(posedge clk) begin
		if (calc_start) begin
			res_band_q <= in_band_q;
			res_min_q  <= upd.min_v;
			res_max_q  <= upd.max_v;
			res_gen_q  <= upd.pub;
		end
	end

	wbs_stats_unit u_stats (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (calc_start),
		.n_in      (upd.count),
		.sum_in    (upd.sum),
		.sqsum_in  (upd.sqsum),
		.done      (calc_done),
		.mean      (calc_mean),
		.deviation (calc_dev)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata_q <= {res_gen_q, res_max_q, res_min_q, calc_dev, calc_mean};
			m_tuser_q <= res_band_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

`default_nettype wire

[sv/wbs_stats_unit.sv]
`default_nettype none

// Turns a closed window's count, sum and sum of squares into the rounded mean
// and the rounded population standard deviation. The product n*sumsq is built
// from two partial products, the mean comes from a restoring divider and the
// deviation from a bitwise search, both resolving one bit per search step.
module wbs_stats_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [wbs_pkg::COUNT_W-1:0]   n_in,
	input  wire logic [wbs_pkg::SUM_W-1:0]     sum_in,
	input  wire logic [wbs_pkg::SQ_W-1:0]      sqsum_in,
	output logic                               done,
	output logic [wbs_pkg::LEVEL_W-1:0]        mean,
	output logic [wbs_pkg::LEVEL_W-1:0]        deviation
);

	import wbs_pkg::*;

	localparam int SQ_LO_W = SQ_W / 2;
	localparam int SQ_HI_W = SQ_W - SQ_LO_W;
	localparam int NQ_W    = COUNT_W + SQ_W;
	localparam int SS_W    = 2 * SUM_W;
	localparam int LIM_W   = NQ_W + 2;
	localparam int NUM_W   = SUM_W + 1;
	localparam int DVS_W   = COUNT_W + 1;
	localparam int ODD_W   = LEVEL_W + 1;
	localparam int P_W     = ODD_W + COUNT_W;
	localparam int BIT_W   = $clog2(LEVEL_W);

	calc_state_t state_q, state_d;

	logic [COUNT_W-1:0]         n_q;
	logic [SUM_W-1:0]           sum_q;
	logic [SQ_W-1:0]            sq_q;
	logic [COUNT_W+SQ_LO_W-1:0] nq_lo_q;
	logic [COUNT_W+SQ_HI_W-1:0] nq_hi_q;
	logic [NQ_W-1:0]            nq_q;
	logic [SS_W-1:0]            ss_q;
	logic [LIM_W-1:0]           lim_q;
	logic [P_W-1:0]             p_q;
	logic [LEVEL_W-1:0]         root_q;
	logic [LEVEL_W-1:0]         quo_q;
	logic [DVS_W-1:0]           rem_q;
	logic [LEVEL_W-1:0]         num_lo_q;
	logic [BIT_W-1:0]           bit_q;

	logic [NUM_W-1:0]           num_full;
	logic [LEVEL_W-1:0]         cand;
	logic [ODD_W-1:0]           odd;
	logic [2*P_W-1:0]           p_sq;
	logic [DVS_W:0]             div_t;
	logic [DVS_W:0]             dvs;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			CS_IDLE:  if (start) state_d = CS_MULA;
			CS_MULA:  state_d = CS_MULB;
			CS_MULB:  state_d = CS_MULC;
			CS_MULC:  state_d = CS_DIFF;
			CS_DIFF:  state_d = CS_ROOTA;
			CS_ROOTA: state_d = CS_ROOTB;
			CS_ROOTB: state_d = (bit_q == '0) ? CS_DONE : CS_ROOTA;
			CS_DONE:  state_d = CS_IDLE;
			default:  state_d = CS_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		done = (state_q == CS_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath helpers: divider numerator 2*sum + n, search candidate and its
	// odd multiplier 2*cand - 1, the square of the search product, and the trial dividend and divisor 2n of the divider.
	always_comb begin
		num_full = {sum_q, 1'b0} + NUM_W'(n_q);
		cand     = root_q | (LEVEL_W'(1) << bit_q);
		odd      = {cand, 1'b0} - ODD_W'(1);
		p_sq     = p_q * p_q;
		div_t    = {rem_q, num_lo_q[LEVEL_W-1]};
		dvs      = {1'b0, n_q, 1'b0};
	end

	// Datapath registers, stepped by the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			CS_IDLE: begin
				if (start) begin
					n_q   <= n_in;
					sum_q <= sum_in;
					sq_q  <= sqsum_in;
				end
			end
			CS_MULA: begin
				nq_lo_q  <= n_q * sq_q[SQ_LO_W-1:0];
				rem_q    <= num_full[NUM_W-1:LEVEL_W];
				num_lo_q <= num_full[LEVEL_W-1:0];
			end
			CS_MULB: begin
				nq_hi_q <= n_q * sq_q[SQ_W-1:SQ_LO_W];
			end
			CS_MULC: begin
				ss_q <= sum_q * sum_q;
				nq_q <= {nq_hi_q, {SQ_LO_W{1'b0}}} + NQ_W'(nq_lo_q);
			end
			CS_DIFF: begin
				// Four times n*sumsq - sum^2, the bound of the deviation search.
				lim_q  <= (nq_q >= NQ_W'(ss_q)) ? {nq_q - NQ_W'(ss_q), 2'b00} : '0;
				root_q <= '0;
				quo_q  <= '0;
				bit_q  <= BIT_W'(LEVEL_W - 1);
			end
			CS_ROOTA: begin
				p_q <= odd * n_q;
			end
			CS_ROOTB: begin
				// Keep the candidate bit while (2r-1)^2 * n^2 stays within the bound.
				if (p_sq <= lim_q) begin
					root_q <= cand;
				end
				// One step of the mean division by 2n.
				if (div_t >= dvs) begin
					rem_q <= DVS_W'(div_t - dvs);
					quo_q <= {quo_q[LEVEL_W-2:0], 1'b1};
				end else begin
					rem_q <= div_t[DVS_W-1:0];
					quo_q <= {quo_q[LEVEL_W-2:0], 1'b0};
				end
				num_lo_q <= num_lo_q << 1;
				bit_q    <= bit_q - BIT_W'(1);
			end
			default: begin
			end
		endcase
	end

	assign mean      = quo_q;
	assign deviation = root_q;

endmodule

`default_nettype wire
